/* sv/pidl_pkg.sv */
// Package for the positional insert/delete list.
// Holds field widths, action and status codes, and the controller/datapath link types.
// No dependencies.
package pidl_pkg;

  localparam int unsigned ActW   = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 8;

  localparam int unsigned CapacityDef = 128;

  localparam logic [ActW-1:0] ActInsert = 3'd0;
  localparam logic [ActW-1:0] ActEdit   = 3'd1;
  localparam logic [ActW-1:0] ActDelete = 3'd2;
  localparam logic [ActW-1:0] ActRead   = 3'd3;
  localparam logic [ActW-1:0] ActClear  = 3'd4;

  localparam logic [StatW-1:0] StOk     = 2'd0;
  localparam logic [StatW-1:0] StFull   = 2'd1;
  localparam logic [StatW-1:0] StEmpty  = 2'd2;
  localparam logic [StatW-1:0] StBadPos = 2'd3;

  typedef enum logic [2:0] {
    KindNone,
    KindWrite,
    KindUp,
    KindDown,
    KindRead
  } kind_e;

  typedef struct packed {
    logic load;
    logic seed;
    logic rd;
    logic rd_pos;
    logic wr_val;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  up;
    logic  last;
    logic  out_free;
  } dp_stat_t;

endpackage

/* sv/pidl_if.sv */
// Handshake channel interfaces for the positional insert/delete list.
// Depends on pidl_pkg for field widths.
interface pidl_in_if import pidl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ActW-1:0]         action;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

interface pidl_out_if import pidl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] read_value;
  logic [CountW-1:0]       count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink (input valid, status, read_value, count, output ready);
endinterface

/* sv/pidl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pidl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pidl_ctrl.sv */
// Controller state machine for the positional insert/delete list.
// Depends on pidl_pkg; drives datapath commands from datapath status.
module pidl_ctrl import pidl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WVAL  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.kind)
          KindWrite: begin
            cmd_o.wr_val = 1'b1;
            state_d      = S_FIN;
          end
          KindUp, KindDown: begin
            cmd_o.seed = 1'b1;
            state_d    = S_SHIFT;
          end
          KindRead: begin
            cmd_o.rd_pos = 1'b1;
            state_d      = S_FIN;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.rd = 1'b1;
        if (stat_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = stat_i.up ? S_WVAL : S_FIN;
      end
      S_WVAL: begin
        cmd_o.wr_val = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/pidl_dp.sv */
// Datapath for the positional insert/delete list: item registers, fill count,
// shift pointers, entry RAM and result register. Depends on pidl_pkg and pidl_ram.
module pidl_dp import pidl_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ActW-1:0]         action_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [DataW-1:0] value_i,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] read_value_o,
  output logic [CountW-1:0]       count_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam logic [CountW-1:0] CapCount = CountW'(Capacity);

  logic [ActW-1:0]         act_q;
  logic [PosW-1:0]         pos_q;
  logic [DataW-1:0]        val_q;
  logic [CountW-1:0]       count_q, count_d;
  logic [PosW-1:0]         ptr_q, ptr_d;
  logic                    pend_q;
  logic [AddrW-1:0]        pend_addr_q, pend_addr_d;
  logic                    out_valid_q, out_valid_d;
  logic [StatW-1:0]        out_status_q;
  logic [DataW-1:0]        out_rd_q;
  logic [CountW-1:0]       out_count_q;

  logic                    is_ins, is_edit, is_del, is_read, is_clr;
  logic [StatW-1:0]        st_c;
  logic                    ok_c;
  kind_e                   kind_c;
  logic [CountW-1:0]       count_m1;

  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [DataW-1:0]        ram_wdata, ram_rdata;

  assign is_ins   = (act_q == ActInsert);
  assign is_edit  = (act_q == ActEdit);
  assign is_del   = (act_q == ActDelete);
  assign is_read  = (act_q == ActRead);
  assign is_clr   = (act_q == ActClear);
  assign count_m1 = count_q - CountW'(1);

  always_comb begin
    st_c = StOk;
    if (is_ins) begin
      if (count_q >= CapCount) begin
        st_c = StFull;
      end else if (CountW'(pos_q) > count_q) begin
        st_c = StBadPos;
      end
    end else if (is_edit || is_del || is_read) begin
      if (count_q == '0) begin
        st_c = StEmpty;
      end else if (CountW'(pos_q) >= count_q) begin
        st_c = StBadPos;
      end
    end
  end

  assign ok_c = (st_c == StOk);

  always_comb begin
    kind_c = KindNone;
    if (ok_c) begin
      if (is_ins) begin
        kind_c = (CountW'(pos_q) == count_q) ? KindWrite : KindUp;
      end else if (is_edit) begin
        kind_c = KindWrite;
      end else if (is_del) begin
        kind_c = (CountW'(pos_q) == count_m1) ? KindNone : KindDown;
      end else if (is_read) begin
        kind_c = KindRead;
      end
    end
  end

  assign stat_o.kind     = kind_c;
  assign stat_o.up       = is_ins;
  assign stat_o.last     = is_ins ? (ptr_q == pos_q) : (CountW'(ptr_q) == count_m1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ptr_d       = ptr_q;
    pend_addr_d = pend_addr_q;
    if (cmd_i.seed) begin
      ptr_d = is_ins ? PosW'(count_m1) : pos_q + PosW'(1);
    end else if (cmd_i.rd) begin
      ptr_d       = is_ins ? ptr_q - PosW'(1) : ptr_q + PosW'(1);
      pend_addr_d = is_ins ? ptr_q[AddrW-1:0] + AddrW'(1) : ptr_q[AddrW-1:0] - AddrW'(1);
    end
  end

  assign ram_re    = cmd_i.rd || cmd_i.rd_pos;
  assign ram_raddr = cmd_i.rd ? ptr_q[AddrW-1:0] : pos_q[AddrW-1:0];
  assign ram_we    = pend_q || cmd_i.wr_val;
  assign ram_waddr = pend_q ? pend_addr_q : pos_q[AddrW-1:0];
  assign ram_wdata = pend_q ? ram_rdata : val_q;

  pidl_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish && ok_c) begin
      if (is_ins) begin
        count_d = count_q + CountW'(1);
      end else if (is_del) begin
        count_d = count_m1;
      end else if (is_clr) begin
        count_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= cmd_i.rd;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    if (cmd_i.load) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.finish) begin
      out_status_q <= st_c;
      out_rd_q     <= (is_read && ok_c) ? ram_rdata : '0;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_rd_q;
  assign count_o      = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("fill count above capacity");

  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && cmd_i.wr_val))
    else $error("shift write and value write collide");

  a_rd_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && cmd_i.rd) |-> (pend_addr_q != ptr_q[AddrW-1:0]))
    else $error("shift reads an entry being written");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("result not presented after finish");
`endif

endmodule

/* sv/positional_insert_delete_list.sv */
// Positional insert/delete list: a dense list of up to Capacity signed 32-bit entries
// held in one single-port-write, single-port-read RAM. One item is handled at a time.
// An insert at a position p below the count moves count-p entries up, then writes
// the new value; a delete at p below count-1 moves count-p-1 entries down. An append,
// edit, read, clear, delete of the last entry and a rejected item move no entries. The
// next item can be taken in the same cycle that the result is presented. Entries move
// one per cycle through the RAM's registered read port, which sets the rate. A finished
// result waits in an output register while the next item is taken.
// Depends on pidl_pkg, pidl_if, pidl_ram, pidl_ctrl and pidl_dp.
module positional_insert_delete_list import pidl_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidl_in_if.sink           in_i,
  pidl_out_if.source        out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pidl_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (in_i.action),
    .position_i   (in_i.position),
    .value_i      (in_i.value),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_o     (out_o.status),
    .read_value_o (out_o.read_value),
    .count_o      (out_o.count)
  );

endmodule
